/* rtl/core/mwu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwu_pkg
// Shared types, codes and helpers of the memory watchpoint unit.
// ----------------------------------------------------------------------------
package mwu_pkg;

  localparam int unsigned AddrBits   = 16;
  localparam int unsigned TableDepth = 1 << AddrBits;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [1:0]          entry_t;

  localparam entry_t MaskRead  = 2'h1;
  localparam entry_t MaskWrite = 2'h2;
  localparam entry_t MaskBoth  = 2'h3;
  localparam entry_t MaskNone  = 2'h0;

  localparam logic [7:0] CountMax = 8'hFF;

  typedef enum logic [2:0] {
    OP_ARM        = 3'd0,
    OP_DISARM     = 3'd1,
    OP_CLEAR_ALL  = 3'd2,
    OP_STEP_BEGIN = 3'd3,
    OP_BUS_ACCESS = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_BOTH  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic        en;
    logic [2:0]  op;
    logic [1:0]  kind;
    addr_t       idx;
    entry_t      entry;
    logic [31:0] seq;
  } win_upd_t;

  typedef struct packed {
    logic        hit_flag;
    logic [15:0] hit_addr;
    logic        hit_write;
    logic [7:0]  count;
    logic [31:0] first_seq;
  } win_state_t;

  function automatic entry_t mode_mask(logic [1:0] mode);
    entry_t m;
    unique case (mode)
      MODE_READ:  m = MaskRead;
      MODE_WRITE: m = MaskWrite;
      MODE_BOTH:  m = MaskBoth;
      default:    m = MaskNone;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/mwu_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwu_if
// Request and response channels of the memory watchpoint unit.
// ----------------------------------------------------------------------------
interface mwu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] address;
  logic [1:0]  watch_mode;
  logic [1:0]  access_kind;
  logic [31:0] sequence_req;

  modport source (output valid, opcode, address, watch_mode, access_kind, sequence_req,
                  input ready);
  modport sink (input valid, opcode, address, watch_mode, access_kind, sequence_req,
                output ready);
endinterface

interface mwu_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit_pending;
  logic [15:0] hit_address;
  logic        hit_is_write;
  logic [7:0]  access_count;
  logic [31:0] first_sequence;
  logic [1:0]  watch_bits;

  modport source (output valid, hit_pending, hit_address, hit_is_write, access_count,
                  first_sequence, watch_bits, input ready);
  modport sink (input valid, hit_pending, hit_address, hit_is_write, access_count,
                first_sequence, watch_bits, output ready);
endinterface
`default_nettype wire

/* rtl/core/mwu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwu_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mwu_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mwu_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwu_window
// Step window state: hit latch, access counter and first sequence number.
// ----------------------------------------------------------------------------
module mwu_window (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mwu_pkg::win_upd_t   upd_i,
  output mwu_pkg::win_state_t      state_o
);
  import mwu_pkg::*;

  win_state_t win_q, win_d;
  entry_t     need;

  always_comb begin
    unique case (upd_i.kind)
      KIND_READ:  need = MaskRead;
      KIND_WRITE: need = MaskWrite;
      default:    need = MaskNone;
    endcase
  end

  always_comb begin
    win_d = win_q;
    if (upd_i.en) begin
      unique case (upd_i.op)
        OP_STEP_BEGIN: begin
          win_d = '0;
        end
        OP_BUS_ACCESS: begin
          if (win_q.count == '0) begin
            win_d.first_seq = upd_i.seq;
          end
          if (win_q.count != CountMax) begin
            win_d.count = win_q.count + 8'd1;
          end
          if (!win_q.hit_flag && need != MaskNone && (upd_i.entry & need) == need) begin
            win_d.hit_flag  = 1'b1;
            win_d.hit_addr  = 16'(upd_i.idx);
            win_d.hit_write = (upd_i.kind == KIND_WRITE);
          end
        end
        default: begin
          win_d = win_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign state_o = win_d;

endmodule
`default_nettype wire

/* rtl/core/memory_watchpoint_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_watchpoint_unit
// Data watchpoint table with step window hit tracking.
// ----------------------------------------------------------------------------
// The watch table sits in one RAM of 2**AddrBits two-bit entries. Each word
// reads its entry in the accept cycle; an arm or disarm word writes it back
// in the execute state once the response register is free, where the result
// is registered for the response. Words follow one per cycle while the
// response side keeps taking results; a write-back to the address the next
// word reads is forwarded. After reset, and after each clear-all word, a sweep
// zeroes the table one entry per cycle; no request word is taken during the
// sweep. Every request word yields exactly one response word.
module memory_watchpoint_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  mwu_req_if.sink   req_i,
  mwu_rsp_if.source rsp_o
);
  import mwu_pkg::*;

  state_e      state_q, state_d;
  addr_t       sweep_q, sweep_d;
  logic [2:0]  op_q;
  addr_t       idx_q;
  logic [1:0]  mode_q;
  logic [1:0]  kind_q;
  logic [31:0] seq_q;
  logic        fwd_q, fwd_d;
  entry_t      fwd_data_q;

  logic        out_valid_q, out_valid_d;
  win_state_t  out_win_q;
  entry_t      out_bits_q;

  addr_t       idx_in;
  logic        out_free, exec_ok, in_ready, accept;
  entry_t      rdata, old_entry, new_entry;
  logic        we;
  addr_t       waddr;
  entry_t      wdata;
  win_upd_t    upd;
  win_state_t  win_next;

  assign idx_in   = addr_t'(req_i.address);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign exec_ok  = (state_q == ST_EXEC) && out_free;
  assign in_ready = (state_q == ST_IDLE) || (exec_ok && op_q != OP_CLEAR_ALL);
  assign accept   = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  assign old_entry = fwd_q ? fwd_data_q : rdata;

  always_comb begin
    unique case (op_q)
      OP_ARM:       new_entry = old_entry | mode_mask(mode_q);
      OP_DISARM:    new_entry = old_entry & ~mode_mask(mode_q);
      OP_CLEAR_ALL: new_entry = MaskNone;
      default:      new_entry = old_entry;
    endcase
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = sweep_q;
      wdata = MaskNone;
    end else begin
      we    = exec_ok && (op_q == OP_ARM || op_q == OP_DISARM);
      waddr = idx_q;
      wdata = new_entry;
    end
  end

  assign fwd_d = accept ? (we && (waddr == idx_in)) : fwd_q;

  mwu_ram #(
    .Depth (TableDepth),
    .Width ($bits(entry_t))
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (idx_in),
    .rdata_o (rdata)
  );

  always_comb begin
    upd.en    = exec_ok;
    upd.op    = op_q;
    upd.kind  = kind_q;
    upd.idx   = idx_q;
    upd.entry = old_entry;
    upd.seq   = seq_q;
  end

  mwu_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .state_o (win_next)
  );

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    unique case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + addr_t'(1);
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_ok) begin
          if (op_q == OP_CLEAR_ALL) begin
            state_d = ST_CLEAR;
            sweep_d = '0;
          end else if (!accept) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (exec_ok) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= req_i.opcode;
      idx_q      <= idx_in;
      mode_q     <= req_i.watch_mode;
      kind_q     <= req_i.access_kind;
      seq_q      <= req_i.sequence_req;
      fwd_data_q <= wdata;
    end
    if (exec_ok) begin
      out_win_q  <= win_next;
      out_bits_q <= new_entry;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.hit_pending    = out_win_q.hit_flag;
  assign rsp_o.hit_address    = out_win_q.hit_addr;
  assign rsp_o.hit_is_write   = out_win_q.hit_write;
  assign rsp_o.access_count   = out_win_q.count;
  assign rsp_o.first_sequence = out_win_q.first_seq;
  assign rsp_o.watch_bits     = out_bits_q;

endmodule
`default_nettype wire
